/* hdl/voxel_face_cull_mesher_unit_macros.svh */
// assertion macros used by the checker file
`ifndef VOXEL_FACE_CULL_MESHER_UNIT_MACROS_SVH
`define VOXEL_FACE_CULL_MESHER_UNIT_MACROS_SVH

// clocked check, switched off while reset is held
`define VFC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked check that also looks at reset itself
`define VFC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

/* hdl/vfc_pkg.sv */
`default_nettype none

package vfc_pkg;

    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_ABSENT = 2'd1,
        KIND_MESH   = 2'd2,
        KIND_TEST   = 2'd3
    } kind_t;

    // face directions, plus a code for the tested block itself
    localparam logic [2:0] DIR_LEFT   = 3'd0;
    localparam logic [2:0] DIR_RIGHT  = 3'd1;
    localparam logic [2:0] DIR_BACK   = 3'd2;
    localparam logic [2:0] DIR_FRONT  = 3'd3;
    localparam logic [2:0] DIR_BOTTOM = 3'd4;
    localparam logic [2:0] DIR_TOP    = 3'd5;
    localparam logic [2:0] DIR_SELF   = 3'd6;

    localparam int         FACE_COUNT  = 6;
    localparam logic [16:0] VERTEX_STEP = 17'd4;

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  chunk_index;
        logic [3:0]  pos_x;
        logic [3:0]  pos_y;
        logic [3:0]  pos_z;
        logic [7:0]  block_type;
    } req_t;

    typedef struct packed {
        logic [3:0]  face_x;
        logic [3:0]  face_y;
        logic [3:0]  face_z;
        logic [2:0]  face_dir;
        logic [16:0] vertex_base;
        logic        last_face;
    } face_t;

endpackage

`default_nettype wire

/* hdl/vfc_ram.sv */
`default_nettype none

module vfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/vfc_nbr.sv */
`default_nettype none

module vfc_nbr #(
    parameter int CHUNK_SIDE   = 16,
    parameter int CHUNK_HEIGHT = 16,
    parameter int GRID_SIDE    = 4,
    parameter int REACH        = 16,
    parameter int AW           = 16
) (
    input  logic [3:0]       chunk,
    input  logic [3:0]       x,
    input  logic [3:0]       y,
    input  logic [3:0]       z,
    input  logic [2:0]       dir,
    input  logic [REACH-1:0] present,
    output logic [AW-1:0]    addr,
    output logic             open
);

    import vfc_pkg::*;

    localparam int XW    = $clog2(CHUNK_SIDE);
    localparam int YW    = $clog2(CHUNK_HEIGHT);
    localparam int CHW   = (REACH > 1) ? $clog2(REACH) : 1;
    localparam int CELLS = CHUNK_SIDE * CHUNK_SIDE * CHUNK_HEIGHT;

    logic [XW-1:0] xs, zs, nx, nz;
    logic [YW-1:0] ys, ny;
    logic [4:0]    cw, base, col, nc;
    logic          row_first, row_last, col_first, col_last;
    logic          bound_open, absent;

    always_comb
    begin
        xs = XW'(x);
        ys = YW'(y);
        zs = XW'(z);
        cw = {1'b0, chunk};

        // column part of the chunk slot: start of the row it sits in
        base = '0;
        for (int k = 1; k < GRID_SIDE; k++)
        begin
            if (int'(chunk) >= k * GRID_SIDE)
            begin
                base = 5'(k * GRID_SIDE);
            end
        end
        col       = cw - base;
        row_first = int'(chunk) < GRID_SIDE;
        row_last  = int'(chunk) >= (GRID_SIDE - 1) * GRID_SIDE;
        col_first = (col == 5'd0);
        col_last  = (int'(col) == GRID_SIDE - 1);

        nx         = xs;
        ny         = ys;
        nz         = zs;
        nc         = cw;
        bound_open = 1'b0;

        unique case (dir)
            DIR_LEFT:
            begin
                if (xs == '0)
                begin
                    nx         = XW'(CHUNK_SIDE - 1);
                    nc         = cw - 5'(GRID_SIDE);
                    bound_open = row_first;
                end
                else
                begin
                    nx = xs - 1'b1;
                end
            end
            DIR_RIGHT:
            begin
                if (xs == XW'(CHUNK_SIDE - 1))
                begin
                    nx         = '0;
                    nc         = cw + 5'(GRID_SIDE);
                    bound_open = row_last;
                end
                else
                begin
                    nx = xs + 1'b1;
                end
            end
            DIR_BACK:
            begin
                if (zs == '0)
                begin
                    nz         = XW'(CHUNK_SIDE - 1);
                    nc         = cw - 5'd1;
                    bound_open = col_first;
                end
                else
                begin
                    nz = zs - 1'b1;
                end
            end
            DIR_FRONT:
            begin
                if (zs == XW'(CHUNK_SIDE - 1))
                begin
                    nz         = '0;
                    nc         = cw + 5'd1;
                    bound_open = col_last;
                end
                else
                begin
                    nz = zs + 1'b1;
                end
            end
            DIR_BOTTOM:
            begin
                if (ys == '0)
                begin
                    bound_open = 1'b1;
                end
                else
                begin
                    ny = ys - 1'b1;
                end
            end
            DIR_TOP:
            begin
                if (ys == YW'(CHUNK_HEIGHT - 1))
                begin
                    bound_open = 1'b1;
                end
                else
                begin
                    ny = ys + 1'b1;
                end
            end
            default:
            begin
                // the tested block itself
            end
        endcase

        // slots no write can reach are never present
        if (int'(nc) >= REACH)
        begin
            absent = 1'b1;
        end
        else
        begin
            absent = !present[nc[CHW-1:0]];
        end
        open = bound_open || absent;

        addr = AW'(nc[CHW-1:0]) * AW'(CELLS) + AW'(nx)
             + AW'(CHUNK_SIDE) * (AW'(ny) + AW'(CHUNK_HEIGHT) * AW'(nz));
    end

endmodule

`default_nettype wire

/* hdl/voxel_face_cull_mesher_unit.sv */
// test item: accepted in S_IDLE, seven single-port voxel reads in S_PROBE, a compare in S_LAST, then
// one face beat per cycle in S_EMIT while face_ready does not stall it; face beats are registered
// a write goes through S_WRITE, other items finish in S_IDLE; no new item is taken until the last is done
// rate is set by the single-ported voxel memory, one read per cycle
// async active-low reset clears the sequencer, presence flags, vertex counter and air code;
// voxel memory is not cleared, there is no clearing pass
`default_nettype none

module voxel_face_cull_mesher_unit #(
    parameter int CHUNK_SIDE   = 16,
    parameter int CHUNK_HEIGHT = 16,
    parameter int GRID_SIDE    = 4,
    parameter int TYPE_BITS    = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  vfc_pkg::req_t  req,
    output logic           face_valid,
    input  logic           face_ready,
    output vfc_pkg::face_t face,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [7:0]     cfg_data
);

    import vfc_pkg::*;

    localparam int CHUNK_COUNT = GRID_SIDE * GRID_SIDE;
    // only slots 0..15 can be addressed by a 4-bit chunk index
    localparam int REACH       = (CHUNK_COUNT < 16) ? CHUNK_COUNT : 16;
    localparam int CELLS       = CHUNK_SIDE * CHUNK_SIDE * CHUNK_HEIGHT;
    localparam int DEPTH       = REACH * CELLS;
    localparam int AW          = $clog2(DEPTH);
    localparam int CHW         = (REACH > 1) ? $clog2(REACH) : 1;
    // air compare is as wide as the wider of stored type and air code
    localparam int CMPW        = (TYPE_BITS > 8) ? TYPE_BITS : 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_PROBE,
        S_LAST,
        S_EMIT
    } state_t;

    // control state
    state_t           state_reg, state_next;
    logic [2:0]       iss_reg, iss_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             solid_reg, solid_next;
    logic [5:0]       mask_reg, mask_next;
    logic [16:0]      ctr_reg, ctr_next;
    logic [REACH-1:0] present_reg, present_next;
    logic [7:0]       air_reg, air_next;
    logic             face_valid_reg, face_valid_next;

    // payload
    req_t             item_reg, item_next;
    logic [2:0]       pend_idx_reg, pend_idx_next;
    logic             pend_open_reg, pend_open_next;
    face_t            face_reg, face_next;

    // memory and neighbour unit
    logic                 ram_we;
    logic [TYPE_BITS-1:0] ram_wdata, ram_rdata;
    logic [AW-1:0]        nbr_addr;
    logic                 nbr_open;
    logic [2:0]           probe_dir;

    logic       in_range;
    logic       hit_open;
    logic [2:0] sel_dir;
    logic [5:0] sel_bit, rest;

    // probe order: the block itself first, then the six faces
    assign probe_dir = (state_reg == S_PROBE && iss_reg != 3'd0) ? iss_reg - 3'd1 : DIR_SELF;

    vfc_nbr #(
        .CHUNK_SIDE   (CHUNK_SIDE),
        .CHUNK_HEIGHT (CHUNK_HEIGHT),
        .GRID_SIDE    (GRID_SIDE),
        .REACH        (REACH),
        .AW           (AW)
    ) u_nbr (
        .chunk   (item_reg.chunk_index),
        .x       (item_reg.pos_x),
        .y       (item_reg.pos_y),
        .z       (item_reg.pos_z),
        .dir     (probe_dir),
        .present (present_reg),
        .addr    (nbr_addr),
        .open    (nbr_open)
    );

    vfc_ram #(
        .WIDTH (TYPE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (nbr_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign req_ready  = (state_reg == S_IDLE);
    assign cfg_ready  = 1'b1;
    assign face_valid = face_valid_reg;
    assign face       = face_reg;
    assign ram_wdata  = TYPE_BITS'(item_reg.block_type);

    // lowest pending face direction goes out first
    always_comb
    begin
        sel_dir = 3'd0;
        for (int d = FACE_COUNT - 1; d >= 0; d--)
        begin
            if (mask_reg[d])
            begin
                sel_dir = 3'(d);
            end
        end
        sel_bit = 6'b000001 << sel_dir;
        rest    = mask_reg & ~sel_bit;
    end

    always_comb
    begin
        state_next      = state_reg;
        iss_next        = iss_reg;
        pend_valid_next = 1'b0;
        solid_next      = solid_reg;
        mask_next       = mask_reg;
        ctr_next        = ctr_reg;
        present_next    = present_reg;
        air_next        = air_reg;
        face_valid_next = face_valid_reg;
        item_next       = item_reg;
        pend_idx_next   = pend_idx_reg;
        pend_open_next  = pend_open_reg;
        face_next       = face_reg;
        ram_we          = 1'b0;

        in_range = (int'(req.chunk_index) < CHUNK_COUNT)
                && (int'(req.pos_x) < CHUNK_SIDE)
                && (int'(req.pos_z) < CHUNK_SIDE)
                && (int'(req.pos_y) < CHUNK_HEIGHT);

        if (cfg_valid)
        begin
            air_next = cfg_data;
        end

        // read data of the previous probe is back: forced-open or air means visible
        hit_open = pend_open_reg || (CMPW'(ram_rdata) == CMPW'(air_reg));
        if (pend_valid_reg)
        begin
            if (pend_idx_reg == DIR_SELF)
            begin
                solid_next = !hit_open;
            end
            else
            begin
                mask_next[pend_idx_reg] = hit_open;
            end
        end

        if (face_ready)
        begin
            face_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next = req;
                    if (req.kind == KIND_MESH)
                    begin
                        ctr_next = '0;
                    end
                    else if (in_range)
                    begin
                        unique case (req.kind)
                            KIND_WRITE:
                            begin
                                state_next = S_WRITE;
                            end
                            KIND_ABSENT:
                            begin
                                present_next[req.chunk_index[CHW-1:0]] = 1'b0;
                            end
                            KIND_TEST:
                            begin
                                iss_next   = 3'd0;
                                mask_next  = '0;
                                solid_next = 1'b0;
                                state_next = S_PROBE;
                            end
                            KIND_MESH:
                            begin
                                // handled above
                            end
                        endcase
                    end
                end
            end
            S_WRITE:
            begin
                ram_we = 1'b1;
                present_next[item_reg.chunk_index[CHW-1:0]] = 1'b1;
                state_next = S_IDLE;
            end
            S_PROBE:
            begin
                pend_valid_next = 1'b1;
                pend_idx_next   = probe_dir;
                pend_open_next  = nbr_open;
                iss_next        = iss_reg + 3'd1;
                if (iss_reg == 3'(FACE_COUNT))
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                if (solid_reg && mask_next != '0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (!face_valid_reg || face_ready)
                begin
                    face_next.face_x      = item_reg.pos_x;
                    face_next.face_y      = item_reg.pos_y;
                    face_next.face_z      = item_reg.pos_z;
                    face_next.face_dir    = sel_dir;
                    face_next.vertex_base = ctr_reg;
                    face_next.last_face   = (rest == '0);
                    face_valid_next       = 1'b1;
                    ctr_next              = ctr_reg + VERTEX_STEP;
                    mask_next             = rest;
                    if (rest == '0)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers and the registered output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            iss_reg        <= '0;
            pend_valid_reg <= 1'b0;
            solid_reg      <= 1'b0;
            mask_reg       <= '0;
            ctr_reg        <= '0;
            present_reg    <= '0;
            air_reg        <= '0;
            face_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            iss_reg        <= iss_next;
            pend_valid_reg <= pend_valid_next;
            solid_reg      <= solid_next;
            mask_reg       <= mask_next;
            ctr_reg        <= ctr_next;
            present_reg    <= present_next;
            air_reg        <= air_next;
            face_valid_reg <= face_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        pend_idx_reg  <= pend_idx_next;
        pend_open_reg <= pend_open_next;
        face_reg      <= face_next;
    end

endmodule

`default_nettype wire

/* hdl/vfc_check.sv */
`default_nettype none
`include "voxel_face_cull_mesher_unit_macros.svh"

module vfc_check (
    input logic           clk,
    input logic           rst_n,
    input logic           req_ready,
    input logic           face_valid,
    input logic           face_ready,
    input vfc_pkg::face_t face
);

    // a stalled face beat holds
    `VFC_ASSERT(a_face_hold, face_valid && !face_ready |=> face_valid && $stable(face), "face beat changed while stalled")

    // more faces of the same test pending: no new request taken
    `VFC_ASSERT(a_busy_mid_test, face_valid && !face.last_face |-> !req_ready, "request open mid test")

    // faces of one test follow back to back with rising direction and base stepping by four
    `VFC_ASSERT(a_face_seq, face_valid && face_ready && !face.last_face |=> face_valid && face.vertex_base == $past(face.vertex_base) + 17'd4 && face.face_dir > $past(face.face_dir), "face sequence broken")

    // nothing shown straight out of reset
    `VFC_ASSERT_RST(a_reset_quiet, $rose(rst_n) |-> !face_valid, "face valid out of reset")

endmodule

bind voxel_face_cull_mesher_unit vfc_check u_vfc_check (.*);

`default_nettype wire
